// File: rtl/peer_table_with_aging_macros.svh
// assertion macros for the peer table
// both sample on the rising clock edge and are off while reset is asserted
`ifndef PEER_TABLE_WITH_AGING_MACROS_SVH
`define PEER_TABLE_WITH_AGING_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define PTWA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define PTWA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ptwa_pkg.sv
`timescale 1ns / 1ps

package ptwa_pkg;

	// field widths
	localparam int ADDR_W    = 64;
	localparam int PORT_W    = 16;
	localparam int TIME_W    = 32;
	localparam int TMO_W     = 16;
	localparam int CMD_W     = 3;
	localparam int OUT_CNT_W = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd30;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_SELF_HI = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SELF_LO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SELF_PT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd3;

	// command codes; 6 and 7 are no-ops
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT    = 3'd0,
		CMD_REMOVE    = 3'd1,
		CMD_KEEPALIVE = 3'd2,
		CMD_QUERY     = 3'd3,
		CMD_PURGE     = 3'd4,
		CMD_TICK      = 3'd5
	} cmd_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_FINISH
	} state_t;

endpackage

// File: rtl/peer_table_with_aging.sv
`timescale 1ns / 1ps
// Peer table with aging. A command word is taken when start is high and busy is low; its
// result appears on found, entry_count, full_res and purged_count for exactly one cycle
// with done high, and the receiver cannot hold it off. Insert, remove, keep-alive, query
// and purge walk the entry store one entry per cycle through a single key comparator and
// age subtractor, then drain the read stage and do the finishing write, after which the
// result register shows the outcome; tick and the unused codes go straight from idle to
// the finishing write and the result register. A new word may be started in
// the cycle its predecessor's result is shown. Valid bits clear at reset, so the table is
// usable right after reset with no clearing pass. Configuration writes are taken at any
// time and must only be issued while busy is low.
`include "peer_table_with_aging_macros.svh"

module peer_table_with_aging
	import ptwa_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_wdata,
	// command word
	input  logic                 start,
	output logic                 busy,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [ADDR_W-1:0]    addr_hi,
	input  logic [ADDR_W-1:0]    addr_lo,
	input  logic [PORT_W-1:0]    port,
	// result word
	output logic                 done,
	output logic                 found,
	output logic [OUT_CNT_W-1:0] entry_count,
	output logic                 full_res,
	output logic [OUT_CNT_W-1:0] purged_count
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	state_t state_q, state_d;

	// configuration registers
	logic [ADDR_W-1:0] self_hi_q, self_lo_q;
	logic [PORT_W-1:0] self_pt_q;
	logic [TMO_W-1:0]  timeout_q;

	// command operands
	logic [CMD_W-1:0]  cmd_q;
	logic [ADDR_W-1:0] key_hi_q, key_lo_q;
	logic [PORT_W-1:0] key_pt_q;

	// entry store
	logic [ADDR_W-1:0] mem_hi   [ENTRIES];
	logic [ADDR_W-1:0] mem_lo   [ENTRIES];
	logic [PORT_W-1:0] mem_pt   [ENTRIES];
	logic [TIME_W-1:0] mem_seen [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0]      count_q;
	logic [TIME_W-1:0]  now_q;

	// scan position and read stage
	logic [IW-1:0]     idx_q, idx_s1;
	logic              scan_s1;
	logic [ADDR_W-1:0] rd_hi_s1, rd_lo_s1;
	logic [PORT_W-1:0] rd_pt_s1;
	logic [TIME_W-1:0] rd_seen_s1;

	// scan findings
	logic          hit_q, free_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	logic [CW-1:0] purged_q;

	// result registers
	logic                 done_q, found_q, full_q;
	logic [OUT_CNT_W-1:0] entry_count_q, purged_count_q;

	logic accept, is_scan_cmd, is_purge;
	logic [ADDR_W-1:0] cmp_hi, cmp_lo;
	logic [PORT_W-1:0] cmp_pt;
	logic key_eq, entry_vld, stale;
	logic [TIME_W-1:0] age;
	logic purge_drop, lookup_hit, lookup_free;
	logic wr_key, wr_seen, clr_hit, full_nxt, count_inc, count_dec;
	logic [IW-1:0] wr_idx;
	logic [CW-1:0] count_fin;
	logic [CW+OUT_CNT_W-1:0] count_ext, purged_ext;

	assign accept      = start && !busy;
	assign is_scan_cmd = (cmd == CMD_INSERT) || (cmd == CMD_REMOVE) ||
	                     (cmd == CMD_KEEPALIVE) || (cmd == CMD_QUERY) ||
	                     (cmd == CMD_PURGE);
	assign is_purge    = (cmd_q == CMD_PURGE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and busy
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = is_scan_cmd ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_hi_q <= '0;
			self_lo_q <= '0;
			self_pt_q <= '0;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SELF_HI: self_hi_q <= cfg_wdata;
				CFG_SELF_LO: self_lo_q <= cfg_wdata;
				CFG_SELF_PT: self_pt_q <= cfg_wdata[PORT_W-1:0];
				CFG_TIMEOUT: timeout_q <= cfg_wdata[TMO_W-1:0];
			endcase
		end
	end

	// operand capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			key_hi_q <= addr_hi;
			key_lo_q <= addr_lo;
			key_pt_q <= port;
		end
	end

	// shared comparator: own key for purge, command key otherwise
	always_comb begin
		cmp_hi      = is_purge ? self_hi_q : key_hi_q;
		cmp_lo      = is_purge ? self_lo_q : key_lo_q;
		cmp_pt      = is_purge ? self_pt_q : key_pt_q;
		key_eq      = (rd_hi_s1 == cmp_hi) && (rd_lo_s1 == cmp_lo) && (rd_pt_s1 == cmp_pt);
		entry_vld   = valid_q[idx_s1];
		age         = now_q - rd_seen_s1;
		stale       = age > {{(TIME_W-TMO_W){1'b0}}, timeout_q};
		purge_drop  = scan_s1 && is_purge && entry_vld && (key_eq || stale);
		lookup_hit  = scan_s1 && !is_purge && entry_vld && key_eq && !hit_q;
		lookup_free = scan_s1 && !entry_vld && !free_q;
	end

	// finishing step of a command
	always_comb begin
		wr_key    = 1'b0;
		wr_seen   = 1'b0;
		clr_hit   = 1'b0;
		full_nxt  = 1'b0;
		count_inc = 1'b0;
		count_dec = 1'b0;
		wr_idx    = hit_idx_q;
		if (state_q == ST_FINISH) begin
			case (cmd_q)
				CMD_INSERT: begin
					if (hit_q) begin
						wr_seen = 1'b1;
					end else if (free_q) begin
						wr_key    = 1'b1;
						wr_seen   = 1'b1;
						wr_idx    = free_idx_q;
						count_inc = 1'b1;
					end else begin
						full_nxt = 1'b1;
					end
				end
				CMD_REMOVE: begin
					if (hit_q) begin
						clr_hit   = 1'b1;
						count_dec = 1'b1;
					end
				end
				CMD_KEEPALIVE: begin
					if (hit_q) begin
						wr_seen = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (count_inc) begin
			count_fin = count_q + CW'(1);
		end else if (count_dec) begin
			count_fin = count_q - CW'(1);
		end else begin
			count_fin = count_q;
		end
		count_ext  = {{OUT_CNT_W{1'b0}}, count_fin};
		purged_ext = {{OUT_CNT_W{1'b0}}, purged_q};
	end

	// entry store write and scan read
	always_ff @(posedge clk) begin
		if (wr_key) begin
			mem_hi[wr_idx] <= key_hi_q;
			mem_lo[wr_idx] <= key_lo_q;
			mem_pt[wr_idx] <= key_pt_q;
		end
		if (wr_seen) begin
			mem_seen[wr_idx] <= now_q;
		end
		if (state_q == ST_SCAN) begin
			rd_hi_s1   <= mem_hi[idx_q];
			rd_lo_s1   <= mem_lo[idx_q];
			rd_pt_s1   <= mem_pt[idx_q];
			rd_seen_s1 <= mem_seen[idx_q];
		end
	end

	// scan counter and findings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			idx_s1     <= '0;
			scan_s1    <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
			purged_q   <= '0;
		end else begin
			scan_s1 <= (state_q == ST_SCAN);
			idx_s1  <= idx_q;
			if (accept) begin
				idx_q    <= '0;
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
				purged_q <= '0;
			end else begin
				if (state_q == ST_SCAN) begin
					idx_q <= idx_q + IW'(1);
				end
				if (lookup_hit) begin
					hit_q     <= 1'b1;
					hit_idx_q <= idx_s1;
				end
				if (lookup_free) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_s1;
				end
				if (purge_drop) begin
					purged_q <= purged_q + CW'(1);
				end
			end
		end
	end

	// valid bits, entry count and seconds counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			now_q   <= '0;
		end else begin
			if (purge_drop) begin
				valid_q[idx_s1] <= 1'b0;
				count_q         <= count_q - CW'(1);
			end
			if (state_q == ST_FINISH) begin
				count_q <= count_fin;
				if (wr_key) begin
					valid_q[free_idx_q] <= 1'b1;
				end
				if (clr_hit) begin
					valid_q[hit_idx_q] <= 1'b0;
				end
				if (cmd_q == CMD_TICK) begin
					now_q <= now_q + TIME_W'(1);
				end
			end
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q         <= 1'b0;
			found_q        <= 1'b0;
			full_q         <= 1'b0;
			entry_count_q  <= '0;
			purged_count_q <= '0;
		end else begin
			done_q <= (state_q == ST_FINISH);
			if (state_q == ST_FINISH) begin
				found_q        <= hit_q;
				full_q         <= full_nxt;
				entry_count_q  <= count_ext[OUT_CNT_W-1:0];
				purged_count_q <= purged_ext[OUT_CNT_W-1:0];
			end
		end
	end

	assign done         = done_q;
	assign found        = found_q;
	assign full_res     = full_q;
	assign entry_count  = entry_count_q;
	assign purged_count = purged_count_q;

	// checks
	`PTWA_ASSERT_NOW(a_count_matches_valid, state_q == ST_IDLE,
		count_q == CW'($countones(valid_q)), "entry count differs from valid bits")
	`PTWA_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy,
		"accepted word did not make the block busy")
	`PTWA_ASSERT_NOW(a_full_excludes_hit, done && full_res,
		!found && (purged_count == '0), "full reported together with a hit or purge")

endmodule

// File: tb/peer_table_with_aging_check.sv
`timescale 1ns / 1ps

module peer_table_with_aging_check
	import ptwa_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_wdata,
	input  logic                 start,
	input  logic                 busy,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [ADDR_W-1:0]    addr_hi,
	input  logic [ADDR_W-1:0]    addr_lo,
	input  logic [PORT_W-1:0]    port,
	input  logic                 done,
	input  logic                 found,
	input  logic [OUT_CNT_W-1:0] entry_count,
	input  logic                 full_res,
	input  logic [OUT_CNT_W-1:0] purged_count,
	output int                   fail_count,
	output int                   outstanding,
	output int                   cmds_taken
);

	typedef struct packed {
		logic                 found;
		logic [OUT_CNT_W-1:0] count;
		logic                 full;
		logic [OUT_CNT_W-1:0] purged;
	} peer_result_t;

	// shadow copy of the peer store and the seconds counter
	logic              peer_valid [ENTRIES];
	logic [ADDR_W-1:0] peer_hi    [ENTRIES];
	logic [ADDR_W-1:0] peer_lo    [ENTRIES];
	logic [PORT_W-1:0] peer_port  [ENTRIES];
	logic [TIME_W-1:0] peer_seen  [ENTRIES];
	logic [TIME_W-1:0] now_s;

	// shadow copy of the node registers
	logic [ADDR_W-1:0] own_hi;
	logic [ADDR_W-1:0] own_lo;
	logic [PORT_W-1:0] own_port;
	logic [TMO_W-1:0]  timeout;

	// results owed by the block, oldest first
	peer_result_t awaited_results [$];

	function automatic int lookup_peer(logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] lo,
		logic [PORT_W-1:0] pt);
		int i;
		for (i = 0; i < ENTRIES; i++)
			if (peer_valid[i] && peer_hi[i] == hi && peer_lo[i] == lo && peer_port[i] == pt)
				return i;
		return -1;
	endfunction

	// apply one command word to the shadow store and return what the block must report
	function automatic peer_result_t apply_command(logic [CMD_W-1:0] op,
		logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] lo, logic [PORT_W-1:0] pt);
		peer_result_t r;
		int hit;
		int slot;
		int i;
		int n;
		logic [TIME_W-1:0] age;
		r = '0;
		hit = -1;
		slot = -1;
		n = 0;
		if (op <= CMD_QUERY) begin
			hit = lookup_peer(hi, lo, pt);
			r.found = (hit >= 0);
		end
		case (op)
			CMD_INSERT: begin
				if (hit >= 0) begin
					peer_seen[hit] = now_s;
				end else begin
					// lowest free entry takes the new key
					for (i = 0; i < ENTRIES && slot < 0; i++)
						if (!peer_valid[i])
							slot = i;
					if (slot < 0) begin
						r.full = 1'b1;
					end else begin
						peer_valid[slot] = 1'b1;
						peer_hi[slot]    = hi;
						peer_lo[slot]    = lo;
						peer_port[slot]  = pt;
						peer_seen[slot]  = now_s;
					end
				end
			end
			CMD_REMOVE: begin
				if (hit >= 0)
					peer_valid[hit] = 1'b0;
			end
			CMD_KEEPALIVE: begin
				if (hit >= 0)
					peer_seen[hit] = now_s;
			end
			CMD_PURGE: begin
				// drop own key and anything older than the timeout
				for (i = 0; i < ENTRIES; i++) begin
					if (peer_valid[i]) begin
						age = now_s - peer_seen[i];
						if ((peer_hi[i] == own_hi && peer_lo[i] == own_lo &&
							peer_port[i] == own_port) || age > timeout) begin
							peer_valid[i] = 1'b0;
							n++;
						end
					end
				end
				r.purged = n[OUT_CNT_W-1:0];
			end
			CMD_TICK: begin
				now_s = now_s + 1'b1;
			end
			default: begin
			end
		endcase
		n = 0;
		for (i = 0; i < ENTRIES; i++)
			if (peer_valid[i])
				n++;
		r.count = n[OUT_CNT_W-1:0];
		return r;
	endfunction

	task automatic check_field(string label, int want, int got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, label, want, got);
		end
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		peer_result_t want;
		int i;
		if (!arst_n) begin
			for (i = 0; i < ENTRIES; i++) begin
				peer_valid[i] = 1'b0;
				peer_hi[i]    = '0;
				peer_lo[i]    = '0;
				peer_port[i]  = '0;
				peer_seen[i]  = '0;
			end
			now_s    = '0;
			own_hi   = '0;
			own_lo   = '0;
			own_port = '0;
			timeout  = TIMEOUT_RESET;
			awaited_results.delete();
			outstanding = 0;
			cmds_taken  = 0;
		end else begin
			// result word against the oldest prediction
			if (done) begin
				if (awaited_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result word with no command outstanding", $realtime);
				end else begin
					want = awaited_results.pop_front();
					check_field("found", want.found, found);
					check_field("entry_count", want.count, entry_count);
					check_field("full_res", want.full, full_res);
					check_field("purged_count", want.purged, purged_count);
				end
			end
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_SELF_HI: own_hi   = cfg_wdata;
					CFG_SELF_LO: own_lo   = cfg_wdata;
					CFG_SELF_PT: own_port = cfg_wdata[PORT_W-1:0];
					CFG_TIMEOUT: timeout  = cfg_wdata[TMO_W-1:0];
					default: begin
					end
				endcase
			end
			// accepted command word
			if (start && !busy) begin
				awaited_results.push_back(apply_command(cmd, addr_hi, addr_lo, port));
				cmds_taken++;
			end
			outstanding = awaited_results.size();
		end
	end

endmodule

// File: tb/peer_table_with_aging_test.sv
`timescale 1ns / 1ps

module peer_table_with_aging_test;
	import ptwa_pkg::*;

	localparam int ENTRIES         = 16;
	localparam int POOL            = 20;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 96;
	localparam int STALL_LIMIT     = 2000;
	localparam int SETTLE_CYCLES   = ENTRIES + 4;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_wdata;
	logic                 start;
	logic                 busy;
	logic [CMD_W-1:0]     cmd;
	logic [ADDR_W-1:0]    addr_hi;
	logic [ADDR_W-1:0]    addr_lo;
	logic [PORT_W-1:0]    port;
	logic                 done;
	logic                 found;
	logic [OUT_CNT_W-1:0] entry_count;
	logic                 full_res;
	logic [OUT_CNT_W-1:0] purged_count;

	int fail_count;
	int outstanding;
	int cmds_taken;

	// keys reused often so that lookups hit and the table fills
	logic [ADDR_W-1:0] pool_hi [POOL];
	logic [ADDR_W-1:0] pool_lo [POOL];
	logic [PORT_W-1:0] pool_pt [POOL];

	int          op_seen [8];
	int          settings_used = 0;
	int unsigned stall_run = 0;

	peer_table_with_aging #(.ENTRIES(ENTRIES)) DUT (.*);

	peer_table_with_aging_check #(.ENTRIES(ENTRIES)) table_check (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog on cycles with no word moving on any port
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			stall_run <= 0;
		end else if (stall_run >= STALL_LIMIT) begin
			$display("no progress for %0d cycles", STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_run <= stall_run + 1;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [CMD_W-1:0] pick_op();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 30) return CMD_INSERT;
		if (roll < 40) return CMD_REMOVE;
		if (roll < 52) return CMD_KEEPALIVE;
		if (roll < 64) return CMD_QUERY;
		if (roll < 74) return CMD_PURGE;
		if (roll < 96) return CMD_TICK;
		return CMD_W'($urandom_range(6, 7));
	endfunction

	function automatic void new_key(int k);
		pool_hi[k] = rand64();
		pool_lo[k] = rand64();
		pool_pt[k] = PORT_W'($urandom);
	endfunction

	// present one command word and hold it until the block takes it
	task automatic issue(logic [CMD_W-1:0] op, logic [ADDR_W-1:0] hi,
		logic [ADDR_W-1:0] lo, logic [PORT_W-1:0] pt);
		int seen;
		seen = cmds_taken;
		start   <= 1'b1;
		cmd     <= op;
		addr_hi <= hi;
		addr_lo <= lo;
		port    <= pt;
		do @(negedge clk); while (cmds_taken == seen);
		op_seen[op]++;
	endtask

	task automatic issue_key(logic [CMD_W-1:0] op, int k);
		issue(op, pool_hi[k], pool_lo[k], pool_pt[k]);
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// hold off until every result word is back and the block is idle
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0 || busy);
	endtask

	task automatic program_node(logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] lo,
		logic [PORT_W-1:0] pt, logic [TMO_W-1:0] tmo);
		logic [63:0] junk;
		junk = rand64();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SELF_HI;
		cfg_wdata <= hi;
		@(negedge clk);
		cfg_index <= CFG_SELF_LO;
		cfg_wdata <= lo;
		@(negedge clk);
		// upper bits of the narrow registers are don't-care
		cfg_index <= CFG_SELF_PT;
		cfg_wdata <= {junk[63:16], pt};
		@(negedge clk);
		cfg_index <= CFG_TIMEOUT;
		cfg_wdata <= {junk[47:0], tmo};
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int ph;
		int n;
		int k;
		int burst;
		int own_k;
		logic [TMO_W-1:0] tmo;
		logic [CMD_W-1:0] op;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_SELF_HI;
		cfg_wdata = '0;
		start     = 1'b0;
		cmd       = CMD_QUERY;
		addr_hi   = '0;
		addr_lo   = '0;
		port      = '0;
		// all-zero key, all-ones key, checkerboard key, the rest random
		for (k = 0; k < POOL; k++)
			new_key(k);
		pool_hi[0] = '0;
		pool_lo[0] = '0;
		pool_pt[0] = '0;
		pool_hi[1] = '1;
		pool_lo[1] = '1;
		pool_pt[1] = '1;
		pool_hi[2] = 64'haaaa_aaaa_aaaa_aaaa;
		pool_lo[2] = 64'h5555_5555_5555_5555;
		pool_pt[2] = 16'ha5a5;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset registers: own key is all zero, timeout 30
		issue_key(CMD_QUERY, 1);
		issue_key(CMD_REMOVE, 1);
		issue_key(CMD_KEEPALIVE, 1);
		issue_key(CMD_INSERT, 1);
		issue_key(CMD_INSERT, 1);
		issue_key(CMD_INSERT, 0);
		issue_key(CMD_KEEPALIVE, 1);
		issue_key(CMD_QUERY, 0);
		issue(3'd6, '1, '0, '1);
		issue(3'd7, '0, '1, '0);
		// own key goes on purge
		issue_key(CMD_PURGE, 0);
		issue_key(CMD_REMOVE, 1);
		issue_key(CMD_INSERT, 0);
		issue_key(CMD_INSERT, 1);
		issue_key(CMD_REMOVE, 0);
		// fills the hole left at entry zero
		issue_key(CMD_INSERT, 2);
		drain();

		// zero timeout: anything a tick old is stale
		program_node(pool_hi[5], pool_lo[5], pool_pt[5], 16'd0);
		issue_key(CMD_TICK, 3);
		issue_key(CMD_INSERT, 3);
		issue_key(CMD_PURGE, 3);
		issue_key(CMD_TICK, 3);
		issue_key(CMD_KEEPALIVE, 3);
		issue_key(CMD_PURGE, 3);
		issue_key(CMD_TICK, 3);
		issue_key(CMD_PURGE, 3);
		drain();

		// random phases, each under its own register setting
		for (ph = 0; ph < PHASES; ph++) begin
			for (k = 0; k < 4; k++)
				new_key($urandom_range(3, POOL - 1));
			case (ph)
				0:       tmo = 16'hffff;
				1:       tmo = 16'd0;
				2:       tmo = 16'd3;
				3:       tmo = 16'd1;
				4:       tmo = TMO_W'($urandom_range(2, 10));
				default: tmo = TIMEOUT_RESET;
			endcase
			own_k = (ph == 0) ? 1 : (ph == 1) ? 0 : $urandom_range(0, POOL - 1);
			program_node(pool_hi[own_k], pool_lo[own_k], pool_pt[own_k], tmo);
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				burst = $urandom_range(1, 12);
				for (k = 0; k < burst && n < ITEMS_PER_PHASE; k++) begin
					op = pick_op();
					if ($urandom_range(0, 99) < 85)
						issue_key(op, $urandom_range(0, POOL - 1));
					else
						issue(op, rand64(), rand64(), PORT_W'($urandom));
					n++;
				end
				// gap between bursts; phase two skips the random pauses
				if ($urandom_range(0, 24) == 0)
					drain();
				else if (ph != 2 && $urandom_range(0, 3) != 0)
					pause($urandom_range(1, 16));
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("%0d commands: %0d insert, %0d remove, %0d keep-alive, %0d query, %0d purge, %0d tick, %0d unused",
			cmds_taken, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
			op_seen[5], op_seen[6] + op_seen[7]);
		$display("%0d register settings, timeouts 0 through 65535, %0d-key peer pool",
			settings_used, POOL);
		if (fail_count == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/ptwa_pkg.sv
rtl/peer_table_with_aging.sv
tb/peer_table_with_aging_check.sv
tb/peer_table_with_aging_test.sv
